@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/plcr_pkg.sv @@
// Types and constants shared by the colour ramp modules.
package plcr_pkg;

	// Item commands
	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ORDER = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PERCENT_MODE = 2'd0,
		REG_MIN_CATEGORY = 2'd1,
		REG_MAX_CATEGORY = 2'd2
	} reg_idx_t;

	localparam int CFG_W     = 16;
	localparam int POS_W     = 16;
	localparam int CH_W      = 8;
	localparam int LANES     = 3;
	localparam int COL_W     = LANES * CH_W;
	localparam int NUM_W     = CH_W + POS_W;
	localparam int DIV_STEPS = CH_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Order tracking starts below every legal raw position
	localparam logic signed [POS_W:0] LAST_RESET = -17'sd65536;

	// x / 100 as (x * 41943) >> 22, off by at most one for x below 2^23
	localparam logic [15:0] RECIP_100   = 16'd41943;
	localparam int          RECIP_SHIFT = 22;
	localparam logic [6:0]  PCT_FULL    = 7'd100;

	localparam logic [COL_W-1:0] WHITE = {COL_W{1'b1}};

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_MUL,
		S_ADD_REC,
		S_ADD_FIX,
		S_ADD_COMMIT,
		S_CLEAR,
		S_LK_START,
		S_LK_SCAN,
		S_LK_DRAIN,
		S_LK_MUL,
		S_LK_PREP,
		S_LK_DIV,
		S_LK_FIN,
		S_RESULT
	} plcr_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic add_mul;
		logic add_rec;
		logic add_fix;
		logic add_commit;
		logic clear;
		logic scan_start;
		logic scan;
		logic lane_mul;
		logic div_prep;
		logic div_step;
		logic lane_fin;
		logic out_load;
	} plcr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_end;
		logic div_last;
	} plcr_stat_t;

endpackage

@@ rtl/plcr_channels.sv @@
// Handshake channel interfaces for input items and result items.
interface plcr_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [15:0] point_position;
	logic [7:0]        point_red;
	logic [7:0]        point_green;
	logic [7:0]        point_blue;
	logic signed [15:0] query_category;

	modport source (
		output valid, command, point_position, point_red, point_green, point_blue,
			query_category,
		input  ready
	);
	modport sink (
		input  valid, command, point_position, point_red, point_green, point_blue,
			query_category,
		output ready
	);
endinterface

interface plcr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       covered;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (
		output valid, status, covered, red, green, blue,
		input  ready
	);
	modport sink (
		input  valid, status, covered, red, green, blue,
		output ready
	);
endinterface

@@ rtl/plcr_ctrl.sv @@
// Controller state machine sequencing add, lookup and clear items.
module plcr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  plcr_pkg::cmd_t        in_command,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	input  plcr_pkg::plcr_stat_t  stat,
	output plcr_pkg::plcr_cmd_t   cmd
);
	import plcr_pkg::*;

	plcr_state_t state_q, state_d;
	logic        out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_command)
						CMD_ADD:    state_d = S_ADD_MUL;
						CMD_LOOKUP: state_d = S_LK_START;
						CMD_CLEAR:  state_d = S_CLEAR;
						default:    state_d = S_RESULT;
					endcase
				end
			end
			S_ADD_MUL: begin
				cmd.add_mul = 1'b1;
				state_d     = S_ADD_REC;
			end
			S_ADD_REC: begin
				cmd.add_rec = 1'b1;
				state_d     = S_ADD_FIX;
			end
			S_ADD_FIX: begin
				cmd.add_fix = 1'b1;
				state_d     = S_ADD_COMMIT;
			end
			S_ADD_COMMIT: begin
				cmd.add_commit = 1'b1;
				state_d        = S_RESULT;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_RESULT;
			end
			S_LK_START: begin
				cmd.scan_start = 1'b1;
				state_d        = S_LK_SCAN;
			end
			S_LK_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_d = S_LK_DRAIN;
				end
			end
			// spare state: the last read was compared on the final scan cycle
			S_LK_DRAIN: begin
				state_d = S_LK_MUL;
			end
			S_LK_MUL: begin
				cmd.lane_mul = 1'b1;
				state_d      = S_LK_PREP;
			end
			S_LK_PREP: begin
				cmd.div_prep = 1'b1;
				state_d      = S_LK_DIV;
			end
			S_LK_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_LK_FIN;
				end
			end
			S_LK_FIN: begin
				cmd.lane_fin = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/plcr_dp.sv @@
// Datapath: configuration, point memory, segment scan, dividers and result register.
module plcr_dp #(
	parameter int MAX_POINTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [plcr_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [plcr_pkg::CFG_W-1:0]         cfg_data,
	input  logic signed [plcr_pkg::POS_W-1:0]  point_position,
	input  logic [plcr_pkg::CH_W-1:0]          point_red,
	input  logic [plcr_pkg::CH_W-1:0]          point_green,
	input  logic [plcr_pkg::CH_W-1:0]          point_blue,
	input  logic signed [plcr_pkg::POS_W-1:0]  query_category,
	input  plcr_pkg::plcr_cmd_t                cmd,
	output plcr_pkg::plcr_stat_t               stat,
	output plcr_pkg::status_t                  status,
	output logic                               covered,
	output logic [plcr_pkg::CH_W-1:0]          red,
	output logic [plcr_pkg::CH_W-1:0]          green,
	output logic [plcr_pkg::CH_W-1:0]          blue
);
	import plcr_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = POS_W + COL_W;

	// configuration
	logic                    pct_mode_q;
	logic signed [POS_W-1:0] min_cat_q;
	logic signed [POS_W-1:0] max_cat_q;

	// latched item
	logic signed [POS_W-1:0] raw_q;
	logic [COL_W-1:0]        col_q;
	logic signed [POS_W-1:0] query_q;

	// table state
	logic [CW-1:0]           count_q;
	logic signed [POS_W:0]   last_q;
	logic [EW-1:0]           mem [MAX_POINTS];

	// percent mapping pipeline
	logic signed [POS_W+1:0] ncat_w;
	logic [NUM_W-1:0]        pct_s1;
	logic [39:0]             rec_w;
	logic [POS_W:0]          quo_s2;
	logic [NUM_W-1:0]        back_w;
	logic [NUM_W-1:0]        rem_pct_w;
	logic [POS_W:0]          quo_fix_w;
	logic signed [POS_W+2:0] mapped_w;
	logic signed [POS_W-1:0] pos_q;

	// add checks
	logic signed [POS_W:0]   raw_ext_w;
	status_t                 add_status;
	logic                    mem_we;
	logic signed [POS_W-1:0] new_pos_w;

	// scan
	logic [CW-1:0]           idx_q;
	logic                    rd_issue;
	logic                    rd_vld_q;
	logic [EW-1:0]           rd_q;
	logic [EW-1:0]           prev_q;
	logic                    have_prev_q;
	logic                    found_q;
	logic [EW-1:0]           seg0_q;
	logic [EW-1:0]           seg1_q;
	logic signed [POS_W-1:0] rd_pos_w;
	logic signed [POS_W-1:0] prev_pos_w;
	logic                    match_w;

	// lanes
	logic signed [POS_W-1:0] p0_w;
	logic signed [POS_W-1:0] p1_w;
	logic signed [POS_W:0]   kd_w;
	logic signed [POS_W:0]   lend_w;
	logic [POS_W-1:0]        k_w;
	logic [POS_W-1:0]        len_w;
	logic                    len_zero_w;
	logic [NUM_W-1:0]        num_w   [LANES];
	logic                    neg_w   [LANES];
	logic [NUM_W-1:0]        num_s1  [LANES];
	logic                    neg_s1  [LANES];
	logic [POS_W-1:0]        rem_q   [LANES];
	logic [CH_W-1:0]         lo_q    [LANES];
	logic [CH_W-1:0]         quo_q   [LANES];
	logic [POS_W:0]          trial_w [LANES];
	logic                    ge_w    [LANES];
	logic [CH_W-1:0]         lane_w  [LANES];
	logic [STEP_W-1:0]       step_q;

	// result
	status_t                 res_status_q;
	logic                    res_cov_q;
	logic [COL_W-1:0]        res_col_q;
	status_t                 out_status_q;
	logic                    out_cov_q;
	logic [COL_W-1:0]        out_col_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_mode_q <= 1'b0;
			min_cat_q  <= 16'sd0;
			max_cat_q  <= 16'sd255;
		end else if (cfg_write_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PERCENT_MODE: pct_mode_q <= cfg_data[0];
				REG_MIN_CATEGORY: min_cat_q  <= cfg_data;
				REG_MAX_CATEGORY: max_cat_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q   <= point_position;
			col_q   <= {point_red, point_green, point_blue};
			query_q <= query_category;
		end
	end

	// Percent to category: min + floor(pct * ncat / 100), clamped to max
	assign ncat_w    = 18'(max_cat_q) - 18'(min_cat_q) + 18'sd1;
	assign rec_w     = 40'(pct_s1) * 40'(RECIP_100);
	assign back_w    = NUM_W'(quo_s2) * NUM_W'(PCT_FULL);
	assign rem_pct_w = pct_s1 - back_w;
	assign quo_fix_w = (rem_pct_w >= NUM_W'(PCT_FULL)) ? quo_s2 + 17'd1 : quo_s2;
	assign mapped_w  = 19'(min_cat_q) + $signed({2'b00, quo_fix_w});

	always_ff @(posedge clk) begin
		if (cmd.add_mul) begin
			pct_s1 <= {17'd0, raw_q[6:0]} * {7'd0, ncat_w[POS_W:0]};
		end
		if (cmd.add_rec) begin
			quo_s2 <= rec_w[RECIP_SHIFT +: POS_W+1];
		end
		if (cmd.add_fix) begin
			pos_q <= (mapped_w > 19'(max_cat_q)) ? max_cat_q : mapped_w[POS_W-1:0];
		end
	end

	// Add checks: range, then order, then full table
	assign raw_ext_w = 17'(raw_q);

	always_comb begin
		if (max_cat_q < min_cat_q) begin
			add_status = ST_RANGE;
		end else if (pct_mode_q && (raw_q < 16'sd0 || raw_q > 16'sd100)) begin
			add_status = ST_RANGE;
		end else if (!pct_mode_q && (raw_q < min_cat_q || raw_q > max_cat_q)) begin
			add_status = ST_RANGE;
		end else if (raw_ext_w < last_q) begin
			add_status = ST_ORDER;
		end else if (count_q >= CW'(MAX_POINTS)) begin
			add_status = ST_FULL;
		end else begin
			add_status = ST_OK;
		end
	end

	assign mem_we    = cmd.add_commit && (add_status == ST_OK);
	assign new_pos_w = pct_mode_q ? pos_q : raw_q;

	// Fill count and order tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= LAST_RESET;
		end else if (cmd.clear) begin
			count_q <= '0;
			last_q  <= LAST_RESET;
		end else if (mem_we) begin
			count_q <= count_q + CW'(1);
			last_q  <= raw_ext_w;
		end
	end

	// Point memory: one write port, one registered read port
	assign rd_issue       = cmd.scan && !stat.scan_end;
	assign stat.scan_end  = (idx_q >= count_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= {new_pos_w, col_q};
		end
		if (rd_issue) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	// Segment scan: the last enclosing neighbour pair wins
	assign rd_pos_w   = rd_q[EW-1 -: POS_W];
	assign prev_pos_w = prev_q[EW-1 -: POS_W];
	assign match_w    = rd_vld_q && have_prev_q && (prev_pos_w <= query_q)
		&& (query_q <= rd_pos_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_vld_q    <= 1'b0;
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_vld_q <= rd_issue;
			if (cmd.scan_start) begin
				idx_q       <= '0;
				have_prev_q <= 1'b0;
				found_q     <= 1'b0;
			end else begin
				if (rd_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (rd_vld_q) begin
					have_prev_q <= 1'b1;
				end
				if (match_w) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			prev_q <= rd_q;
		end
		if (match_w) begin
			seg0_q <= prev_q;
			seg1_q <= rd_q;
		end
	end

	// Offset and length of the chosen segment, shared by all channels
	assign p0_w       = seg0_q[EW-1 -: POS_W];
	assign p1_w       = seg1_q[EW-1 -: POS_W];
	assign kd_w       = 17'(query_q) - 17'(p0_w);
	assign lend_w     = 17'(p1_w) - 17'(p0_w);
	assign k_w        = kd_w[POS_W-1:0];
	assign len_w      = lend_w[POS_W-1:0];
	assign len_zero_w = (len_w == '0);
	assign stat.div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// Lane arithmetic: |diff|*k, restoring divide step, signed floor
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic signed [CH_W:0] diff;
			logic signed [CH_W:0] ndiff;
			logic [CH_W-1:0]      a;
			logic [CH_W-1:0]      mag;
			a      = seg0_q[l*CH_W +: CH_W];
			diff   = $signed({1'b0, seg1_q[l*CH_W +: CH_W]}) - $signed({1'b0, a});
			ndiff  = -diff;
			mag    = diff[CH_W] ? ndiff[CH_W-1:0] : diff[CH_W-1:0];
			neg_w[l] = diff[CH_W];
			num_w[l] = {16'd0, mag} * {8'd0, k_w};
			trial_w[l] = {rem_q[l], lo_q[l][CH_W-1]};
			ge_w[l]    = (trial_w[l] >= {1'b0, len_w});
			if (len_zero_w) begin
				lane_w[l] = a;
			end else if (neg_s1[l]) begin
				lane_w[l] = a - quo_q[l] - {7'd0, |rem_q[l]};
			end else begin
				lane_w[l] = a + quo_q[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic [POS_W:0] sub;
			sub = trial_w[l] - {1'b0, len_w};
			if (cmd.lane_mul) begin
				num_s1[l] <= num_w[l];
				neg_s1[l] <= neg_w[l];
			end
			if (cmd.div_prep) begin
				rem_q[l] <= num_s1[l][NUM_W-1:CH_W];
				lo_q[l]  <= num_s1[l][CH_W-1:0];
				quo_q[l] <= '0;
			end else if (cmd.div_step) begin
				rem_q[l] <= ge_w[l] ? sub[POS_W-1:0] : trial_w[l][POS_W-1:0];
				lo_q[l]  <= {lo_q[l][CH_W-2:0], 1'b0};
				quo_q[l] <= {quo_q[l][CH_W-2:0], ge_w[l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_prep) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Result under construction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= ST_OK;
			res_cov_q    <= 1'b0;
			res_col_q    <= '0;
		end else if (cmd.add_commit) begin
			res_status_q <= add_status;
		end else if (cmd.lane_fin) begin
			if (found_q) begin
				res_cov_q <= 1'b1;
				res_col_q <= {lane_w[2], lane_w[1], lane_w[0]};
			end else if (query_q == min_cat_q || query_q == max_cat_q) begin
				res_cov_q <= 1'b1;
				res_col_q <= WHITE;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_cov_q    <= res_cov_q;
			out_col_q    <= res_col_q;
		end
	end

	assign status  = out_status_q;
	assign covered = out_cov_q;
	assign red     = out_col_q[2*CH_W +: CH_W];
	assign green   = out_col_q[CH_W +: CH_W];
	assign blue    = out_col_q[0 +: CH_W];

endmodule

@@ rtl/piecewise_linear_color_ramp.sv @@
// Top level of the piecewise-linear colour ramp.
// Stores up to MAX_POINTS ordered RGB control points and answers colour lookups
// over a signed 16-bit category range, one item at a time. An add passes through
// a short multiply chain that maps percentages to categories. In a lookup the
// single read port of the point memory is scanned one point per cycle over the
// stored points, then the three channels are interpolated in parallel with
// an 8-step restoring divider each. A finished result sits in an output register,
// so the next item is accepted while the previous result waits to be taken.
// The user must write the configuration registers only while no item is in
// flight; the block itself does not enforce this.
`include "assert_macros.svh"

module piecewise_linear_color_ramp #(
	parameter int MAX_POINTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [plcr_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [plcr_pkg::CFG_W-1:0]     cfg_data,
	plcr_in_if.sink                        items,
	plcr_out_if.source                     results
);
	import plcr_pkg::*;

	plcr_cmd_t  cmd;
	plcr_stat_t stat;
	status_t    res_status;

	plcr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (items.valid),
		.in_command (cmd_t'(items.command)),
		.in_ready   (items.ready),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.stat       (stat),
		.cmd        (cmd)
	);

	plcr_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.point_position (items.point_position),
		.point_red      (items.point_red),
		.point_green    (items.point_green),
		.point_blue     (items.point_blue),
		.query_category (items.query_category),
		.cmd            (cmd),
		.stat           (stat),
		.status         (res_status),
		.covered        (results.covered),
		.red            (results.red),
		.green          (results.green),
		.blue           (results.blue)
	);

	assign results.status = res_status;

	// Checks
	`ASSERT_CLK(a_out_free, cmd.out_load |-> (!results.valid || results.ready), "result overwritten before taken")
	`ASSERT_CLK(a_one_item, (items.valid && items.ready) |=> !items.ready, "item accepted while busy")
	`ASSERT_NEVER(a_cmd_onehot, !$onehot0(cmd), "more than one datapath command at once")

endmodule
